>>> rtl/core/workgroup_size_fitter_core_defines.svh
// Assertion macros shared by the workgroup size fitter RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef WORKGROUP_SIZE_FITTER_CORE_DEFINES_SVH
`define WORKGROUP_SIZE_FITTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define WSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("workgroup size fitter: same-cycle check failed");
`define WSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("workgroup size fitter: next-cycle check failed");
`else
`define WSF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/wsf_pkg.sv
// Types, constants and register codes of the workgroup size fitter.
// No dependencies; used by wsf_ctrl, wsf_dp and workgroup_size_fitter_core.
package wsf_pkg;

	localparam int FIELD_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W = 4;
	localparam int ROOT_W = 6;
	localparam int K_W = 7;

	// Cap on the subgroup exponent used for rounding.
	localparam logic [3:0] MAX_SUBGROUP_LOG2 = 4'd10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_INV = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBGROUP = 3'd4;

	localparam logic [FIELD_W-1:0] RST_MAX_X = 11'd1024;
	localparam logic [FIELD_W-1:0] RST_MAX_Y = 11'd1024;
	localparam logic [FIELD_W-1:0] RST_MAX_Z = 11'd64;
	localparam logic [FIELD_W-1:0] RST_MAX_INV = 11'd256;
	localparam logic [FIELD_W-1:0] RST_SUBGROUP = 11'd32;

	localparam logic [FIELD_W-1:0] DEFAULT_AXIS = 11'd4;

	// Last bit index of the restoring divider and of the square root.
	localparam logic [CNT_W-1:0] DIV_LAST = 4'd10;
	localparam logic [CNT_W-1:0] SQRT_LAST = 4'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_XY,
		ST_MUL_XYZ,
		ST_CHECK,
		ST_DIV,
		ST_SQRT,
		ST_HALVE,
		ST_RMUL_XY,
		ST_RMUL_XYZ,
		ST_RPREP,
		ST_RAPPLY
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_XY,
		OP_MUL_XYZ,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SQRT_STEP,
		OP_HALVE,
		OP_RPREP,
		OP_APPLY
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic [CNT_W-1:0] bit_idx;
	} cmd_t;

	typedef struct packed {
		logic over;
		logic halve_go;
	} stat_t;

	typedef struct packed {
		logic [FIELD_W-1:0] max_size_x;
		logic [FIELD_W-1:0] max_size_y;
		logic [FIELD_W-1:0] max_size_z;
		logic [FIELD_W-1:0] max_invocations;
		logic [FIELD_W-1:0] sg_size;
	} cfg_t;

endpackage

>>> rtl/core/wsf_ctrl.sv
// Sequencer of the workgroup size fitter: walks one request through the datapath.
// Depends on wsf_pkg and workgroup_size_fitter_core_defines.svh.
`include "workgroup_size_fitter_core_defines.svh"

module wsf_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  wsf_pkg::stat_t stat,
	output wsf_pkg::cmd_t cmd
);

	wsf_pkg::state_t state_q, state_d;
	logic [wsf_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsf_pkg::ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				wsf_pkg::ST_CHECK: cnt_q <= wsf_pkg::DIV_LAST;
				wsf_pkg::ST_DIV: begin
					if (cnt_q == '0) cnt_q <= wsf_pkg::SQRT_LAST;
					else cnt_q <= cnt_q - 1'b1;
				end
				wsf_pkg::ST_SQRT: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wsf_pkg::ST_IDLE: if (start) state_d = wsf_pkg::ST_MUL_XY;
			wsf_pkg::ST_MUL_XY: state_d = wsf_pkg::ST_MUL_XYZ;
			wsf_pkg::ST_MUL_XYZ: state_d = wsf_pkg::ST_CHECK;
			// Direct-mode and within-limit requests go straight to rounding.
			wsf_pkg::ST_CHECK: state_d = stat.over ? wsf_pkg::ST_DIV : wsf_pkg::ST_RPREP;
			wsf_pkg::ST_DIV: if (cnt_q == '0) state_d = wsf_pkg::ST_SQRT;
			wsf_pkg::ST_SQRT: if (cnt_q == '0) state_d = wsf_pkg::ST_HALVE;
			wsf_pkg::ST_HALVE: if (!stat.halve_go) state_d = wsf_pkg::ST_RMUL_XY;
			wsf_pkg::ST_RMUL_XY: state_d = wsf_pkg::ST_RMUL_XYZ;
			wsf_pkg::ST_RMUL_XYZ: state_d = wsf_pkg::ST_RPREP;
			wsf_pkg::ST_RPREP: state_d = wsf_pkg::ST_RAPPLY;
			wsf_pkg::ST_RAPPLY: state_d = wsf_pkg::ST_IDLE;
			default: state_d = wsf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = wsf_pkg::OP_NONE;
		cmd.bit_idx = cnt_q;
		case (state_q)
			wsf_pkg::ST_IDLE: if (start) cmd.op = wsf_pkg::OP_LOAD;
			wsf_pkg::ST_MUL_XY, wsf_pkg::ST_RMUL_XY: cmd.op = wsf_pkg::OP_MUL_XY;
			wsf_pkg::ST_MUL_XYZ, wsf_pkg::ST_RMUL_XYZ: cmd.op = wsf_pkg::OP_MUL_XYZ;
			wsf_pkg::ST_CHECK: if (stat.over) cmd.op = wsf_pkg::OP_DIV_INIT;
			wsf_pkg::ST_DIV: cmd.op = wsf_pkg::OP_DIV_STEP;
			wsf_pkg::ST_SQRT: cmd.op = wsf_pkg::OP_SQRT_STEP;
			wsf_pkg::ST_HALVE: cmd.op = wsf_pkg::OP_HALVE;
			wsf_pkg::ST_RPREP: cmd.op = wsf_pkg::OP_RPREP;
			wsf_pkg::ST_RAPPLY: cmd.op = wsf_pkg::OP_APPLY;
			default: cmd.op = wsf_pkg::OP_NONE;
		endcase
	end

	assign busy = (state_q != wsf_pkg::ST_IDLE);

	`WSF_ASSERT_NEXT(a_start_enters_mul, clk, arst_n, start && !busy, state_q == wsf_pkg::ST_MUL_XY)
	`WSF_ASSERT_IMP(a_div_cnt_range, clk, arst_n, state_q == wsf_pkg::ST_DIV, cnt_q <= wsf_pkg::DIV_LAST)

endmodule

>>> rtl/core/wsf_dp.sv
// Datapath of the workgroup size fitter: axis registers, shared multiplier,
// restoring divider, bit-serial square root and subgroup rounding.
// Depends on wsf_pkg and workgroup_size_fitter_core_defines.svh.
`include "workgroup_size_fitter_core_defines.svh"

module wsf_dp (
	input  logic clk,
	input  logic arst_n,
	input  wsf_pkg::cmd_t cmd,
	output wsf_pkg::stat_t stat,
	input  wsf_pkg::cfg_t cfg,
	input  logic action,
	input  logic [wsf_pkg::FIELD_W-1:0] req_x,
	input  logic [wsf_pkg::FIELD_W-1:0] req_y,
	input  logic [wsf_pkg::FIELD_W-1:0] req_z,
	output logic done,
	output logic [wsf_pkg::FIELD_W-1:0] local_x,
	output logic [wsf_pkg::FIELD_W-1:0] local_y,
	output logic [wsf_pkg::FIELD_W-1:0] local_z
);

	localparam int W = wsf_pkg::FIELD_W;
	localparam int KW = wsf_pkg::K_W;
	localparam int RW = 22;

	// Index of the lowest set bit; W when the value is zero.
	function automatic logic [3:0] low_bit(input logic [W-1:0] v);
		logic [3:0] n;
		n = 4'(W);
		for (int i = W - 1; i >= 0; i--) begin
			if (v[i]) n = 4'(i);
		end
		return n;
	endfunction

	// Signed division by two, truncating toward zero.
	function automatic logic signed [KW-1:0] div2(input logic signed [KW-1:0] n);
		logic signed [KW-1:0] t;
		t = n + $signed({{(KW-1){1'b0}}, n[KW-1]});
		return t >>> 1;
	endfunction

	// Signed division by three, truncating toward zero; exact for |n| <= 31.
	function automatic logic signed [KW-1:0] div3(input logic signed [KW-1:0] n);
		logic [KW-1:0] a;
		logic [10:0] m;
		logic [KW-1:0] q;
		a = n[KW-1] ? $unsigned(-n) : $unsigned(n);
		m = 11'(a) * 11'd11;
		q = KW'(m[10:5]);
		return n[KW-1] ? -$signed(q) : $signed(q);
	endfunction

	// Round v up to a multiple of 2^k (k capped at 20); saturates to the field.
	function automatic logic [W-1:0] round_up(input logic [W-1:0] v,
			input logic signed [KW-1:0] k);
		logic [4:0] kk;
		logic [RW-1:0] m;
		logic [RW-1:0] s;
		logic [RW-1:0] r;
		kk = (k > 7'sd20) ? 5'd20 : k[4:0];
		m = (RW'(1) << kk) - RW'(1);
		s = RW'(v) + m;
		r = s & ~m;
		if (k[KW-1] || k == '0) return v;
		return (r > RW'({W{1'b1}})) ? {W{1'b1}} : r[W-1:0];
	endfunction

	logic [W-1:0] x_q, y_q, z_q;
	logic act_q;
	logic [2*W-1:0] xy_q;
	logic [3*W-1:0] prod_q;
	logic [W-1:0] rem_q, quo_q;
	logic [wsf_pkg::ROOT_W-1:0] root_q;
	logic signed [KW-1:0] kx_q, ky_q, kz_q;
	logic [W-1:0] local_x_q, local_y_q, local_z_q;
	logic done_q;

	// Load stage: fit-mode default and per-axis clamp.
	logic zero_req;
	logic [W-1:0] fx, fy, fz, lx, ly, lz;
	always_comb begin
		zero_req = (req_x == '0) && (req_y == '0) && (req_z == '0);
		fx = (!action && zero_req) ? wsf_pkg::DEFAULT_AXIS : req_x;
		fy = (!action && zero_req) ? wsf_pkg::DEFAULT_AXIS : req_y;
		fz = (!action && zero_req) ? wsf_pkg::DEFAULT_AXIS : req_z;
		lx = (!action && fx > cfg.max_size_x) ? cfg.max_size_x : fx;
		ly = (!action && fy > cfg.max_size_y) ? cfg.max_size_y : fy;
		lz = (!action && fz > cfg.max_size_z) ? cfg.max_size_z : fz;
	end

	// Shared x*y product, used by the product pass and by the halving loop.
	logic [2*W-1:0] xy_c;
	assign xy_c = (2*W)'(x_q) * (2*W)'(y_q);

	// Divider and square root steps.
	logic [W:0] rem_sh;
	logic [wsf_pkg::ROOT_W-1:0] trial, lim;
	logic [2*wsf_pkg::ROOT_W-1:0] trial_sq;
	always_comb begin
		rem_sh = {rem_q, cfg.max_invocations[cmd.bit_idx]};
		trial = root_q | (wsf_pkg::ROOT_W'(1) << cmd.bit_idx[2:0]);
		trial_sq = (2*wsf_pkg::ROOT_W)'(trial) * (2*wsf_pkg::ROOT_W)'(trial);
		lim = (root_q == '0) ? wsf_pkg::ROOT_W'(1) : root_q;
	end

	assign stat.over = !act_q && (prod_q > (3*W)'(cfg.max_invocations));
	assign stat.halve_go = (xy_c >= (2*W)'(lim)) && !(x_q == W'(1) && y_q == W'(1));

	// Rounding preparation: exponents to add on each axis.
	logic [3:0] nfull, tn, tx, ty, tz;
	logic sg_zero, skip;
	logic [W-1:0] low_mask;
	logic [5:0] tsum;
	logic signed [KW-1:0] need, h2, third, half, kx, ky, kz;
	always_comb begin
		nfull = '0;
		for (int i = 0; i < W; i++) begin
			if (cfg.sg_size[i]) nfull = 4'(i);
		end
		sg_zero = (cfg.sg_size == '0);
		low_mask = (W'(1) << nfull) - W'(1);
		skip = sg_zero || ((prod_q[W-1:0] & low_mask) == '0);
		tn = (nfull < wsf_pkg::MAX_SUBGROUP_LOG2) ? nfull : wsf_pkg::MAX_SUBGROUP_LOG2;
		tx = low_bit(x_q);
		ty = low_bit(y_q);
		tz = low_bit(z_q);
		tsum = 6'(tx) + 6'(ty) + 6'(tz);
		need = $signed(KW'(tn)) - $signed(KW'(tsum));
		h2 = div2(need);
		third = div3(need);
		half = div2(need - third);
		kx = '0;
		ky = '0;
		kz = '0;
		if (z_q == W'(1)) begin
			if (y_q == W'(1)) begin
				kx = $signed(KW'(tn));
			end else if (x_q == W'(1)) begin
				ky = $signed(KW'(tn));
			end else begin
				ky = $signed(KW'(ty)) + h2;
				kx = $signed(KW'(tx)) + need - h2;
			end
		end else if (y_q == W'(1)) begin
			if (x_q == W'(1)) begin
				kz = $signed(KW'(tn));
			end else begin
				kz = $signed(KW'(tz)) + h2;
				kx = $signed(KW'(tx)) + need - h2;
			end
		end else if (x_q == W'(1)) begin
			kz = $signed(KW'(tz)) + h2;
			ky = $signed(KW'(ty)) + need - h2;
		end else begin
			kz = $signed(KW'(tz)) + third;
			ky = $signed(KW'(ty)) + half;
			kx = $signed(KW'(tx)) + need - half;
		end
		// A product that is already a multiple leaves every axis as it is.
		if (skip) begin
			kx = '0;
			ky = '0;
			kz = '0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			wsf_pkg::OP_LOAD: begin
				x_q <= lx;
				y_q <= ly;
				z_q <= lz;
				act_q <= action;
			end
			wsf_pkg::OP_MUL_XY: xy_q <= xy_c;
			wsf_pkg::OP_MUL_XYZ: prod_q <= (3*W)'(xy_q) * (3*W)'(z_q);
			wsf_pkg::OP_DIV_INIT: begin
				rem_q <= '0;
				quo_q <= '0;
				root_q <= '0;
			end
			wsf_pkg::OP_DIV_STEP: begin
				if (rem_sh >= {1'b0, z_q}) begin
					rem_q <= W'(rem_sh - {1'b0, z_q});
					quo_q[cmd.bit_idx] <= 1'b1;
				end else begin
					rem_q <= rem_sh[W-1:0];
				end
			end
			wsf_pkg::OP_SQRT_STEP: begin
				if (trial_sq <= (2*wsf_pkg::ROOT_W)'(quo_q)) root_q <= trial;
			end
			wsf_pkg::OP_HALVE: begin
				if (stat.halve_go) begin
					x_q <= (x_q[W-1:1] == '0) ? W'(1) : {1'b0, x_q[W-1:1]};
					y_q <= (y_q[W-1:1] == '0) ? W'(1) : {1'b0, y_q[W-1:1]};
				end
			end
			wsf_pkg::OP_RPREP: begin
				kx_q <= kx;
				ky_q <= ky;
				kz_q <= kz;
			end
			wsf_pkg::OP_APPLY: begin
				local_x_q <= round_up(x_q, kx_q);
				local_y_q <= round_up(y_q, ky_q);
				local_z_q <= round_up(z_q, kz_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == wsf_pkg::OP_APPLY);
		end
	end

	assign done = done_q;
	assign local_x = local_x_q;
	assign local_y = local_y_q;
	assign local_z = local_z_q;

	`WSF_ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)
	`WSF_ASSERT_NEXT(a_halve_keeps_nonzero, clk, arst_n, cmd.op == wsf_pkg::OP_HALVE, (x_q != '0) && (y_q != '0))

endmodule

>>> rtl/core/workgroup_size_fitter_core.sv
// Top level of the workgroup size fitter: configuration registers, sequencer
// and datapath. Depends on wsf_pkg, wsf_ctrl and wsf_dp.
//
// Usage:
// A request (action, req_x, req_y, req_z) is taken at a rising edge where start
// is high and busy is low. The chosen size appears on local_x/y/z as done
// goes high for exactly one cycle; the receiver has no way to hold it off, and
// a new request may be started in the same cycle that done is shown.
// A request that needs no shrinking (direct mode, or within the invocation limit)
// passes through the product, check, rounding and apply states. Otherwise a
// restoring division, a square root, the halving steps and a recompute of the
// product come between the check and the rounding. The shared multiplier and
// the one-bit-per-cycle divider make these steps sequential; one request is in
// flight at a time.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready;
// writes are meant to happen while busy is low and no result is pending.
// Indexes beyond the register list are ignored.
// After reset the registers hold 1024, 1024, 64, 256 and 32 and the block is
// idle with done low.
module workgroup_size_fitter_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic action,
	input  logic [wsf_pkg::FIELD_W-1:0] req_x,
	input  logic [wsf_pkg::FIELD_W-1:0] req_y,
	input  logic [wsf_pkg::FIELD_W-1:0] req_z,
	output logic done,
	output logic [wsf_pkg::FIELD_W-1:0] local_x,
	output logic [wsf_pkg::FIELD_W-1:0] local_y,
	output logic [wsf_pkg::FIELD_W-1:0] local_z,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [wsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsf_pkg::FIELD_W-1:0] cfg_data
);

	wsf_pkg::cfg_t cfg_q;
	wsf_pkg::cmd_t cmd;
	wsf_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_size_x <= wsf_pkg::RST_MAX_X;
			cfg_q.max_size_y <= wsf_pkg::RST_MAX_Y;
			cfg_q.max_size_z <= wsf_pkg::RST_MAX_Z;
			cfg_q.max_invocations <= wsf_pkg::RST_MAX_INV;
			cfg_q.sg_size <= wsf_pkg::RST_SUBGROUP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wsf_pkg::CFG_MAX_X: cfg_q.max_size_x <= cfg_data;
				wsf_pkg::CFG_MAX_Y: cfg_q.max_size_y <= cfg_data;
				wsf_pkg::CFG_MAX_Z: cfg_q.max_size_z <= cfg_data;
				wsf_pkg::CFG_MAX_INV: cfg_q.max_invocations <= cfg_data;
				wsf_pkg::CFG_SUBGROUP: cfg_q.sg_size <= cfg_data;
				default: ;
			endcase
		end
	end

	wsf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.stat(stat),
		.cmd(cmd)
	);

	wsf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg(cfg_q),
		.action(action),
		.req_x(req_x),
		.req_y(req_y),
		.req_z(req_z),
		.done(done),
		.local_x(local_x),
		.local_y(local_y),
		.local_z(local_z)
	);

endmodule
